### hdl/fcr_pkg.sv
// Shared types, constants and helpers of the framed command receiver.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package fcr_pkg;

  // Sizes of the data paths.
  localparam int unsigned FRAME_BYTES_DEF = 16;
  localparam int unsigned LEN_W           = 4;   // store address / payload length, max 16 entries
  localparam int unsigned TABLE_W         = 36;
  localparam int unsigned SUM_W           = 12;
  localparam int unsigned CMD_COUNT       = 9;
  localparam int unsigned QUEUE_DEPTH     = 2;   // power of two
  localparam int unsigned CFG_IDX_W       = 3;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH_TABLE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ESCAPE_BYTE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_CODE     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NAK_CODE     = 3'd4;

  // Reset values of the registers.
  localparam logic [TABLE_W-1:0] RST_LENGTH_TABLE = 36'hB2241_1100;
  localparam logic [7:0]         RST_START_BYTE   = 8'h7E;
  localparam logic [7:0]         RST_ESCAPE_BYTE  = 8'h7D;
  localparam logic [7:0]         RST_ACK_CODE     = 8'h00;
  localparam logic [7:0]         RST_NAK_CODE     = 8'h01;

  // Kind of an output word.
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_REPLY   = 1'b1;

  // Configuration bundle.
  typedef struct packed {
    logic [TABLE_W-1:0] length_table;
    logic [7:0]         start_byte;
    logic [7:0]         escape_byte;
    logic [7:0]         ack_code;
    logic [7:0]         nak_code;
  } fcr_cfg_t;

  // One job for the back end: a NAK reply, or a good frame (payload then ACK).
  typedef struct packed {
    logic             is_ack;
    logic [LEN_W-1:0] plen;
  } fcr_job_t;

  // Frame store write port.
  typedef struct packed {
    logic             en;
    logic [LEN_W-1:0] addr;
    logic [7:0]       data;
  } fcr_wr_t;

  // Byte-sum fold of the running sum: low byte plus high bits, modulo 256.
  function automatic logic [7:0] fold_sum(input logic [SUM_W-1:0] s);
    logic [7:0] hi;
    hi = 8'(s[SUM_W-1:8]);
    return s[7:0] + hi;
  endfunction

endpackage

### hdl/fcr_front.sv
// Front end: byte de-stuffing, frame parsing, checksum check and frame store writes.
// Depends on fcr_pkg; emits jobs into the queue and write words to the frame store.
`timescale 1ns / 1ps

module fcr_front #(
  parameter int unsigned FRAME_BYTES = fcr_pkg::FRAME_BYTES_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  fcr_pkg::fcr_cfg_t cfg_i,
  input  logic             accept_i,
  input  logic [7:0]       rx_byte_i,
  output logic             push_o,
  output fcr_pkg::fcr_job_t job_o,
  output fcr_pkg::fcr_wr_t wr_o
);

  localparam int unsigned CNT_W = $clog2(FRAME_BYTES + 1);
  localparam int unsigned SUM_W = fcr_pkg::SUM_W;

  logic             esc_q, esc_d;
  logic             await_q, await_d;
  logic             open_q, open_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] exp_q, exp_d;
  logic [SUM_W-1:0] sum_q, sum_d;

  // Frame length for the received command, saturated at the store size.
  logic [3:0]       tbl_entry;
  logic [4:0]       len_raw;
  logic [CNT_W-1:0] len_sat;

  always_comb begin
    tbl_entry = 4'd0;
    if (rx_byte_i < 8'(fcr_pkg::CMD_COUNT)) begin
      tbl_entry = cfg_i.length_table[{rx_byte_i[3:0], 2'b00} +: 4];
    end
    len_raw = {1'b0, tbl_entry} + 5'd1;
    len_sat = (len_raw > 5'(FRAME_BYTES)) ? CNT_W'(FRAME_BYTES) : CNT_W'(len_raw);
  end

  // Parser: one received word per accepted cycle.
  always_comb begin
    logic             ctrl;
    logic             proceed;
    logic [CNT_W-1:0] exp_cur;
    logic [CNT_W-1:0] fill_nx;

    esc_d   = esc_q;
    await_d = await_q;
    open_d  = open_q;
    fill_d  = fill_q;
    exp_d   = exp_q;
    sum_d   = sum_q;
    push_o  = 1'b0;
    job_o   = '0;
    wr_o    = '0;
    ctrl    = 1'b0;
    proceed = 1'b0;
    exp_cur = exp_q;
    fill_nx = fill_q + CNT_W'(1);

    if (accept_i) begin
      if (!esc_q) begin
        if (rx_byte_i == cfg_i.escape_byte) begin
          // The escape meaning wins when escape and start are equal.
          esc_d = 1'b1;
          ctrl  = 1'b1;
        end else if (rx_byte_i == cfg_i.start_byte) begin
          // A new frame; an unfinished one is answered with a NAK.
          if (open_q) begin
            push_o       = 1'b1;
            job_o.is_ack = 1'b0;
          end
          open_d  = 1'b1;
          await_d = 1'b1;
          fill_d  = '0;
          sum_d   = '0;
          ctrl    = 1'b1;
        end
      end else begin
        esc_d = 1'b0;
      end

      if (!ctrl && open_q) begin
        proceed = 1'b1;
        if (await_q) begin
          await_d = 1'b0;
          if (rx_byte_i < 8'(fcr_pkg::CMD_COUNT)) begin
            exp_cur = len_sat;
          end else begin
            // Unknown command: a single NAK, frame closed.
            exp_cur      = '0;
            open_d       = 1'b0;
            push_o       = 1'b1;
            job_o.is_ack = 1'b0;
            proceed      = 1'b0;
          end
          exp_d = exp_cur;
        end

        if (proceed) begin
          if ((fill_q < exp_cur) && (fill_q < CNT_W'(FRAME_BYTES))) begin
            wr_o.en   = 1'b1;
            wr_o.addr = fcr_pkg::LEN_W'(fill_q);
            wr_o.data = rx_byte_i;
            fill_d    = fill_nx;
            if (fill_nx == exp_cur) begin
              // Checksum word: compare with the fold of the earlier words.
              open_d       = 1'b0;
              push_o       = 1'b1;
              job_o.is_ack = (rx_byte_i == fcr_pkg::fold_sum(sum_q));
              job_o.plen   = fcr_pkg::LEN_W'(fill_q);
            end
            sum_d = sum_q + SUM_W'(rx_byte_i);
          end else begin
            open_d = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q   <= 1'b0;
      await_q <= 1'b0;
      open_q  <= 1'b0;
      fill_q  <= '0;
      exp_q   <= '0;
      sum_q   <= '0;
    end else begin
      esc_q   <= esc_d;
      await_q <= await_d;
      open_q  <= open_d;
      fill_q  <= fill_d;
      exp_q   <= exp_d;
      sum_q   <= sum_d;
    end
  end

endmodule

### hdl/fcr_queue.sv
// Short job queue between the front end and the back end.
// Depends on fcr_pkg for the job type and depth.
`timescale 1ns / 1ps

module fcr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  fcr_pkg::fcr_job_t push_job_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output fcr_pkg::fcr_job_t job_o,
  output logic              ack_pending_o
);

  localparam int unsigned DEPTH = fcr_pkg::QUEUE_DEPTH;
  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  fcr_pkg::fcr_job_t      entry_q [DEPTH];
  logic [DEPTH-1:0]       vld_q, vld_d;
  logic [PTR_W-1:0]       wr_ptr_q, rd_ptr_q;

  assign full_o  = vld_q[wr_ptr_q];
  assign valid_o = vld_q[rd_ptr_q];
  assign job_o   = entry_q[rd_ptr_q];

  // A good frame still queued keeps the frame store reserved.
  always_comb begin
    ack_pending_o = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      ack_pending_o = ack_pending_o | (vld_q[i] & entry_q[i].is_ack);
    end
  end

  always_comb begin
    vld_d = vld_q;
    if (pop_i) begin
      vld_d[rd_ptr_q] = 1'b0;
    end
    if (push_i) begin
      vld_d[wr_ptr_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_job_i;
    end
  end

  // Pointers wrap naturally since the depth is a power of two.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      vld_q <= vld_d;
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
    end
  end

endmodule

### hdl/fcr_back.sv
// Back end: frame store, payload drain and reply frame generation with output register.
// Depends on fcr_pkg; takes jobs from the queue and store writes from the front end.
`timescale 1ns / 1ps

module fcr_back #(
  parameter int unsigned FRAME_BYTES = fcr_pkg::FRAME_BYTES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fcr_pkg::fcr_cfg_t cfg_i,
  input  fcr_pkg::fcr_wr_t  wr_i,
  input  logic              job_valid_i,
  input  fcr_pkg::fcr_job_t job_i,
  output logic              pop_o,
  output logic              store_busy_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic              frame_end_o,
  output logic              last_o
);

  localparam int unsigned ADDR_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PAY   = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_ESC   = 3'd3;
  localparam logic [2:0] ST_CODE  = 3'd4;
  localparam logic [2:0] ST_SUM   = 3'd5;

  logic [7:0]        store_q [FRAME_BYTES];
  logic [2:0]        state_q, state_d;
  logic              ack_q, ack_d;
  logic [ADDR_W-1:0] plen_q, plen_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic [ADDR_W-1:0] idx_nx;
  logic              out_valid_q, out_valid_d;
  logic              kind_q, kind_d;
  logic [7:0]        byte_q, byte_d;
  logic              end_q, end_d;
  logic              last_q, last_d;
  logic              load;
  logic              pay_rd;
  logic [7:0]        code;
  logic              need_esc;

  // Frame store, written by the front end.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      store_q[wr_i.addr[ADDR_W-1:0]] <= wr_i.data;
    end
  end

  assign load         = !out_valid_q || out_ready_i;
  assign pay_rd       = (state_q == ST_PAY) && load;
  assign code         = ack_q ? cfg_i.ack_code : cfg_i.nak_code;
  assign need_esc     = (code == cfg_i.escape_byte) || (code == cfg_i.start_byte);
  assign idx_nx       = idx_q + ADDR_W'(1);
  assign store_busy_o = (state_q == ST_PAY);

  // Sequencer: one output word per cycle while the output register can take it.
  always_comb begin
    logic emit;

    emit    = 1'b0;
    state_d = state_q;
    ack_d   = ack_q;
    plen_d  = plen_q;
    idx_d   = idx_q;
    pop_o   = 1'b0;
    kind_d  = kind_q;
    byte_d  = byte_q;
    end_d   = end_q;
    last_d  = last_q;

    case (state_q)
      ST_IDLE: begin
        if (job_valid_i) begin
          pop_o  = 1'b1;
          ack_d  = job_i.is_ack;
          plen_d = job_i.plen[ADDR_W-1:0];
          idx_d  = '0;
          state_d = (job_i.is_ack && (job_i.plen != '0)) ? ST_PAY : ST_START;
        end
      end
      ST_PAY: begin
        // The payload byte itself is read from the store into the output register.
        if (load) begin
          emit   = 1'b1;
          kind_d = fcr_pkg::KIND_PAYLOAD;
          end_d  = (idx_nx == plen_q);
          last_d = 1'b0;
          idx_d  = idx_nx;
          if (idx_nx == plen_q) begin
            state_d = ST_START;
          end
        end
      end
      ST_START: begin
        if (load) begin
          emit    = 1'b1;
          kind_d  = fcr_pkg::KIND_REPLY;
          byte_d  = cfg_i.start_byte;
          end_d   = 1'b0;
          last_d  = 1'b0;
          state_d = need_esc ? ST_ESC : ST_CODE;
        end
      end
      ST_ESC: begin
        if (load) begin
          emit    = 1'b1;
          kind_d  = fcr_pkg::KIND_REPLY;
          byte_d  = cfg_i.escape_byte;
          end_d   = 1'b0;
          last_d  = 1'b0;
          state_d = ST_CODE;
        end
      end
      ST_CODE: begin
        if (load) begin
          emit    = 1'b1;
          kind_d  = fcr_pkg::KIND_REPLY;
          byte_d  = code;
          end_d   = 1'b0;
          last_d  = 1'b0;
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        // The fold of a single byte is the byte itself.
        if (load) begin
          emit    = 1'b1;
          kind_d  = fcr_pkg::KIND_REPLY;
          byte_d  = code;
          end_d   = 1'b1;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Output register valid.
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job and output data registers; payload bytes come straight from the store.
  always_ff @(posedge clk_i) begin
    ack_q  <= ack_d;
    plen_q <= plen_d;
    idx_q  <= idx_d;
    kind_q <= kind_d;
    byte_q <= pay_rd ? store_q[idx_q] : byte_d;
    end_q  <= end_d;
    last_q <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_kind_o  = kind_q;
  assign out_byte_o  = byte_q;
  assign frame_end_o = end_q;
  assign last_o      = last_q;

endmodule

### hdl/framed_command_receiver.sv
// Top level of the framed command receiver: configuration registers and wiring.
// Depends on fcr_pkg, fcr_front, fcr_queue and fcr_back.
`timescale 1ns / 1ps

// Framed command receiver. Received bytes enter on the rx channel, one word per
// cycle; the front end de-stuffs them, parses the frame and checks the folded
// byte-sum in the cycle a word is taken, then hands a job through a two-entry
// queue to the back end, which emits the stored command and arguments followed
// by an ACK reply frame, or a NAK reply frame, through a registered output. The
// back end takes a job while idle and then emits its words in order, so a good
// frame drains up to 19 words (15 payload and 4 reply words) and a NAK reply
// frame is 3 or 4 words. The rx channel is held off while a good frame waits in
// the queue or its payload is read from the frame store, and while the queue
// holds two jobs; otherwise input is taken back to back. Configuration registers
// are written through the cfg channel, which is always ready; the user must
// write them only while idle, and the block itself does not enforce it.

module framed_command_receiver #(
  parameter int unsigned FRAME_BYTES = fcr_pkg::FRAME_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [7:0]                    rx_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          out_kind_o,
  output logic [7:0]                    out_byte_o,
  output logic                          frame_end_o,
  output logic                          last_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fcr_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [fcr_pkg::TABLE_W-1:0]   cfg_data_i
);

  fcr_pkg::fcr_cfg_t cfg_q;
  fcr_pkg::fcr_job_t push_job;
  fcr_pkg::fcr_job_t q_job;
  fcr_pkg::fcr_wr_t  store_wr;
  logic              accept;
  logic              push;
  logic              q_full;
  logic              q_valid;
  logic              pop;
  logic              ack_pending;
  logic              store_busy;

  // Configuration registers; writes to unknown indexes are dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.length_table <= fcr_pkg::RST_LENGTH_TABLE;
      cfg_q.start_byte   <= fcr_pkg::RST_START_BYTE;
      cfg_q.escape_byte  <= fcr_pkg::RST_ESCAPE_BYTE;
      cfg_q.ack_code     <= fcr_pkg::RST_ACK_CODE;
      cfg_q.nak_code     <= fcr_pkg::RST_NAK_CODE;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        fcr_pkg::REG_LENGTH_TABLE: cfg_q.length_table <= cfg_data_i;
        fcr_pkg::REG_START_BYTE:   cfg_q.start_byte   <= cfg_data_i[7:0];
        fcr_pkg::REG_ESCAPE_BYTE:  cfg_q.escape_byte  <= cfg_data_i[7:0];
        fcr_pkg::REG_ACK_CODE:     cfg_q.ack_code     <= cfg_data_i[7:0];
        fcr_pkg::REG_NAK_CODE:     cfg_q.nak_code     <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // The frame store is reserved while a good frame is queued or draining.
  assign in_ready_o = !q_full && !ack_pending && !store_busy;
  assign accept     = in_valid_i && in_ready_o;

  fcr_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .accept_i  (accept),
    .rx_byte_i (rx_byte_i),
    .push_o    (push),
    .job_o     (push_job),
    .wr_o      (store_wr)
  );

  fcr_queue u_queue (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_job_i    (push_job),
    .full_o        (q_full),
    .pop_i         (pop),
    .valid_o       (q_valid),
    .job_o         (q_job),
    .ack_pending_o (ack_pending)
  );

  fcr_back #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .wr_i         (store_wr),
    .job_valid_i  (q_valid),
    .job_i        (q_job),
    .pop_o        (pop),
    .store_busy_o (store_busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_kind_o   (out_kind_o),
    .out_byte_o   (out_byte_o),
    .frame_end_o  (frame_end_o),
    .last_o       (last_o)
  );

endmodule
